FILE: hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Types and constants shared by the positional list engine and its cells.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 5;
  localparam int CNT_OUT_W    = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SET    = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic                     wr;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

FILE: hdl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot. Holds a value, shifts up or down with its neighbors and
// drives its value onto the read bus when its index is addressed.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int W   = 9,
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  ple_pkg::cell_cmd_t               cmd,
  input  logic [W-1:0]                     at,
  input  logic signed [ple_pkg::DATA_W-1:0] left_data,
  input  logic signed [ple_pkg::DATA_W-1:0] right_data,
  output logic signed [ple_pkg::DATA_W-1:0] data,
  output logic signed [ple_pkg::DATA_W-1:0] hit_data
);

  localparam logic [W-1:0] MY_IDX = W'(IDX);

  logic signed [ple_pkg::DATA_W-1:0] data_r;
  logic signed [ple_pkg::DATA_W-1:0] data_nxt;
  logic                              hit;

  assign hit = (at == MY_IDX);

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (MY_IDX > at) begin
        data_nxt = left_data;
      end else if (hit) begin
        data_nxt = cmd.value;
      end
    end
    if (cmd.rem && (MY_IDX >= at)) begin
      data_nxt = right_data;
    end
    if (cmd.wr && hit) begin
      data_nxt = cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign hit_data = hit ? data_r : '0;

endmodule

FILE: hdl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Result: registered; an accepted item's result is in the output register in the next cycle.
// Throughput: 1 item per cycle unless out_ready stalls; every cell shifts, loads
//   or holds in the same cycle, so insert and remove at any position are one step.
// Reset: synchronous, active low; clears the entry count and output valid.
//   Cell contents are not reset; only entries below the count are ever read.
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_operation,
  input  logic [ple_pkg::POS_W-1:0]             in_position,
  input  logic signed [ple_pkg::DATA_W-1:0]     in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_status,
  output logic signed [ple_pkg::DATA_W-1:0]     out_read_value,
  output logic [ple_pkg::CNT_OUT_W-1:0]         out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int W     = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;
  localparam logic [W-1:0] CAP_W = W'(CAPACITY);

  logic [CNT_W-1:0]                  count_r;
  logic [CNT_W-1:0]                  count_nxt;
  logic                              out_valid_r;
  logic                              out_status_r;
  logic signed [ple_pkg::DATA_W-1:0] out_read_value_r;
  logic [ple_pkg::CNT_OUT_W-1:0]     out_entry_count_r;

  logic                              fire;
  ple_pkg::op_t                      op;
  logic [W-1:0]                      pos_ext;
  logic [W-1:0]                      cnt_ext;
  logic [W-1:0]                      at;
  logic                              in_range;
  logic                              full;
  logic                              ok;
  logic                              rd_en;
  ple_pkg::cell_cmd_t                cmd;
  logic signed [ple_pkg::DATA_W-1:0] rd_bus;
  logic signed [ple_pkg::DATA_W-1:0] rd_value;

  logic signed [ple_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic signed [ple_pkg::DATA_W-1:0] cell_hit  [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign op       = ple_pkg::op_t'(in_operation);
  assign pos_ext  = W'(in_position);
  assign cnt_ext  = W'(count_r);
  assign in_range = pos_ext < cnt_ext;
  assign full     = (cnt_ext == CAP_W);

  // operation decode
  always_comb begin
    ok        = 1'b0;
    rd_en     = 1'b0;
    at        = pos_ext;
    count_nxt = count_r;
    cmd       = '0;
    cmd.value = in_value;
    unique case (op)
      ple_pkg::OP_INSERT: begin
        ok = !full;
        if (!in_range) begin
          at = cnt_ext;   // append
        end
        cmd.ins = fire && ok;
        if (fire && ok) begin
          count_nxt = count_r + 1'b1;
        end
      end
      ple_pkg::OP_REMOVE: begin
        ok      = in_range;
        rd_en   = 1'b1;
        cmd.rem = fire && ok;
        if (fire && ok) begin
          count_nxt = count_r - 1'b1;
        end
      end
      ple_pkg::OP_SET: begin
        ok     = in_range;
        cmd.wr = fire && ok;
      end
      ple_pkg::OP_GET: begin
        ok    = in_range;
        rd_en = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ple_pkg::DATA_W-1:0] left_d;
    logic signed [ple_pkg::DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    ple_cell #(
      .W   (W),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .at         (at),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .hit_data   (cell_hit[i])
    );
  end

  // at most one cell drives a nonzero word
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | cell_hit[k];
    end
  end

  assign rd_value = (ok && rd_en) ? rd_bus : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r      <= !ok;
      out_read_value_r  <= rd_value;
      out_entry_count_r <= ple_pkg::CNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    W'(count_r) <= CAP_W)
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op == ple_pkg::OP_INSERT) && !full |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the list");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_read_value_r == '0)
    else $error("error result carries a nonzero value");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("accepted item produced no result");
`endif

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_list_engine. A shadow copy of the list
// predicts the status, read value and entry count of every request. Directed
// cases cover the empty and full lists and out-of-range positions. Random
// traffic then moves the fill level between empty and full, with idle bursts
// on both channels and a closing stretch with no idling at all.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP       = ple_pkg::DEF_CAPACITY;
  localparam int DATA_W         = ple_pkg::DATA_W;
  localparam int POS_W          = ple_pkg::POS_W;
  localparam int CNT_OUT_W      = ple_pkg::CNT_OUT_W;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 850;
  localparam int BURST_ITEMS    = 150;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]     entry_count;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_operation = ple_pkg::OP_GET;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_status;
  logic signed [DATA_W-1:0] out_read_value;
  logic [CNT_OUT_W-1:0]     out_entry_count;

  // shadow list and expected results
  logic signed [DATA_W-1:0] shadow_entries [LIST_CAP];
  int                       shadow_count = 0;
  list_result_t             pending_results [$];

  bit quiet_phase = 1'b0;
  bit sender_gaps = 1'b1;
  int fail_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int error_results = 0;
  int times_full = 0;
  int op_hits [4] = '{0, 0, 0, 0};

  positional_list_engine #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_entry_count(out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the shadow list and return what the block must answer.
  function automatic list_result_t apply_list_op(ple_pkg::op_t op, logic [POS_W-1:0] pos,
                                                 logic signed [DATA_W-1:0] value);
    list_result_t res;
    int           at;
    int           i;
    res.status     = 1'b0;
    res.read_value = '0;
    case (op)
      ple_pkg::OP_INSERT: begin
        if (shadow_count >= LIST_CAP) begin
          res.status = 1'b1;
        end else begin
          at = (int'(pos) >= shadow_count) ? shadow_count : int'(pos);
          for (i = shadow_count; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[at] = value;
          shadow_count++;
          if (shadow_count == LIST_CAP) times_full++;
        end
      end
      ple_pkg::OP_REMOVE: begin
        if (shadow_count == 0 || int'(pos) >= shadow_count) begin
          res.status = 1'b1;
        end else begin
          res.read_value = shadow_entries[pos];
          for (i = int'(pos); i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      ple_pkg::OP_SET: begin
        if (int'(pos) >= shadow_count) res.status = 1'b1;
        else shadow_entries[pos] = value;
      end
      default: begin
        if (int'(pos) >= shadow_count) res.status = 1'b1;
        else res.read_value = shadow_entries[pos];
      end
    endcase
    res.entry_count = shadow_count[CNT_OUT_W-1:0];
    return res;
  endfunction

  // Called in a rising-edge time step; returns in the step of the accepting edge.
  task automatic send_request(ple_pkg::op_t op, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] value);
    int gap;
    if (!quiet_phase && sender_gaps && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= value;
    // inputs only move at rising edges, so ready seen at the falling edge holds
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(apply_list_op(op, pos, value));
    items_sent++;
    op_hits[op]++;
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls: random bursts of low ready between runs of ready.
  int ready_run = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || quiet_phase) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (ready_run > 0) begin
        ready_run--;
      end else begin
        ready_run  = $urandom_range(0, 30);
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
      end
    end
  end

  // Result check: sampled at the falling edge, handshake completes at the next rise.
  always @(negedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0b read_value %0d entry_count %0d",
                 $time, out_status, out_read_value, out_entry_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status) error_results++;
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0b actual %0b",
                   $time, want.status, out_status);
          fail_count++;
        end
        if (out_read_value !== want.read_value) begin
          $display("%0t: read_value mismatch: expected %0d actual %0d",
                   $time, want.read_value, out_read_value);
          fail_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $display("%0t: entry_count mismatch: expected %0d actual %0d",
                   $time, want.entry_count, out_entry_count);
          fail_count++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Empty list errors, append/prepend/middle insert, extremes of value and position.
  task automatic test_edge_requests();
    send_request(ple_pkg::OP_GET,    5'd0,  '0);
    send_request(ple_pkg::OP_REMOVE, 5'd0,  '0);
    send_request(ple_pkg::OP_SET,    5'd0,  32'sd7);
    send_request(ple_pkg::OP_INSERT, 5'd31, 32'sh7FFF_FFFF);   // past count: append
    send_request(ple_pkg::OP_INSERT, 5'd0,  32'sh8000_0000);   // prepend
    send_request(ple_pkg::OP_INSERT, 5'd1,  -32'sd1);          // middle
    send_request(ple_pkg::OP_INSERT, 5'd3,  32'sh5555_5555);   // exactly count: append
    send_request(ple_pkg::OP_GET,    5'd0,  '1);
    send_request(ple_pkg::OP_GET,    5'd3,  '0);
    send_request(ple_pkg::OP_GET,    5'd4,  '0);               // one past the end
    send_request(ple_pkg::OP_GET,    5'd31, '0);
    send_request(ple_pkg::OP_SET,    5'd2,  32'shAAAA_AAAA);
    send_request(ple_pkg::OP_SET,    5'd4,  32'sd1);
    send_request(ple_pkg::OP_REMOVE, 5'd31, '0);
    send_request(ple_pkg::OP_REMOVE, 5'd1,  '0);
    send_request(ple_pkg::OP_REMOVE, 5'd2,  '0);               // last entry
    send_request(ple_pkg::OP_REMOVE, 5'd0,  '0);
    send_request(ple_pkg::OP_GET,    5'd0,  '0);
    send_request(ple_pkg::OP_REMOVE, 5'd0,  '0);
    send_request(ple_pkg::OP_REMOVE, 5'd0,  '0);               // empty again
  endtask

  // Fill to capacity, hit the full-list and top-position cases, then empty it.
  task automatic test_capacity_limit();
    int k;
    for (k = 0; k < LIST_CAP; k++)
      send_request(ple_pkg::OP_INSERT, POS_W'($urandom_range(0, shadow_count)), pick_value());
    send_request(ple_pkg::OP_INSERT, 5'd0, 32'sd123);
    send_request(ple_pkg::OP_SET, POS_W'(LIST_CAP - 1), 32'sh7FFF_FFFF);
    send_request(ple_pkg::OP_GET, POS_W'(LIST_CAP - 1), '0);
    send_request(ple_pkg::OP_GET, POS_W'(LIST_CAP), '0);
    while (shadow_count > 0)
      send_request(ple_pkg::OP_REMOVE, POS_W'($urandom_range(0, shadow_count - 1)), '0);
    send_request(ple_pkg::OP_REMOVE, 5'd31, '0);
  endtask

  // Fill level drifts between filling, balanced and draining modes.
  task automatic test_random_traffic(int n_req);
    int                       k;
    int                       fill_mode;
    int                       r;
    int                       ins_cut;
    int                       rem_cut;
    ple_pkg::op_t             op;
    logic [POS_W-1:0]         pos;
    fill_mode = 1;
    for (k = 0; k < n_req; k++) begin
      if (k % 40 == 0) begin
        fill_mode   = $urandom_range(0, 2);
        sender_gaps = ($urandom_range(0, 3) != 0);
      end
      ins_cut = (fill_mode == 0) ? 60 : (fill_mode == 1) ? 30 : 10;
      rem_cut = ins_cut + ((fill_mode == 2) ? 60 : (fill_mode == 1) ? 30 : 10);
      r = $urandom_range(0, 99);
      if (r < ins_cut) op = ple_pkg::OP_INSERT;
      else if (r < rem_cut) op = ple_pkg::OP_REMOVE;
      else if (r % 2 == 0) op = ple_pkg::OP_SET;
      else op = ple_pkg::OP_GET;
      if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom);
      else if (op == ple_pkg::OP_INSERT || shadow_count == 0)
        pos = POS_W'($urandom_range(0, shadow_count));
      else pos = POS_W'($urandom_range(0, shadow_count - 1));
      send_request(op, pos, pick_value());
    end
  endtask

  // Sender holds off until every outstanding result is back, then resumes.
  task automatic test_drain_pause();
    test_random_traffic(30);
    in_valid <= 1'b0;
    wait_results_drained();
    test_random_traffic(30);
  endtask

  task automatic test_back_to_back();
    quiet_phase = 1'b1;
    test_random_traffic(BURST_ITEMS);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_edge_requests();
    test_capacity_limit();
    test_random_traffic(RANDOM_ITEMS / 2);
    test_drain_pause();
    test_random_traffic(RANDOM_ITEMS / 2 - 60);
    test_back_to_back();
    in_valid <= 1'b0;
    wait_results_drained();
    repeat (5) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      fail_count++;
    end
    $display("Sent %0d requests (insert %0d, remove %0d, set %0d, get %0d), checked %0d results",
             items_sent, op_hits[ple_pkg::OP_INSERT], op_hits[ple_pkg::OP_REMOVE],
             op_hits[ple_pkg::OP_SET], op_hits[ple_pkg::OP_GET], results_checked);
    $display("%0d error responses; list filled to capacity %0d times; %0d mismatches",
             error_results, times_full, fail_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
